@@ sv/cms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants for the color markup stripper.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_DW      = 8;
  localparam int unsigned MAX_REL     = 3;

  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  typedef enum logic [1:0] {
    REG_PARSE_MODE   = 2'd0,
    REG_GLOW_ENABLE  = 2'd1,
    REG_TILDE_ENABLE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_TILDE = 2'd1,
    MODE_GLOW  = 2'd2
  } parse_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_TIL   = 3'd1,
    ST_TA    = 3'd2,
    ST_TAT   = 3'd3,
    ST_TAD1  = 3'd4,
    ST_TAD2  = 3'd5,
    ST_CARET = 3'd6,
    ST_CODE  = 3'd7
  } scan_state_t;

  // Results released by one input item, queued between front and back.
  typedef struct packed {
    logic [1:0]       cnt;   // number of released bytes, 0 means bare end
    logic             fin;   // item closes the string
    logic [2:0][7:0]  bytes;
  } bundle_t;

  function automatic logic code_digit(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_DASH);
  endfunction

endpackage

@@ sv/cms_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_front
// Holds the configuration, runs the markup scanner on each accepted byte and
// forms the group of released bytes for the queue.
// ----------------------------------------------------------------------------
module cms_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [1:0]                cfg_index,
  input  logic [cms_pkg::CFG_DW-1:0] cfg_data,
  input  logic                      accept,
  input  logic [7:0]                in_byte,
  input  logic                      in_end_only,
  input  logic                      in_is_last,
  output logic                      bnd_valid,
  output cms_pkg::bundle_t          bnd
);
  import cms_pkg::*;

  logic [1:0]  parse_mode_r;
  logic        glow_enable_r;
  logic        tilde_enable_r;
  scan_state_t state_r, state_nxt;
  logic [7:0]  hd0_r, hd0_nxt;
  logic [7:0]  hd1_r, hd1_nxt;

  logic        glow_on, tilde_on, fin, do_fresh;
  logic [1:0]  n;
  logic [2:0][7:0] rel;

  assign glow_on  = (parse_mode_r != MODE_COPY) &&
                    ((parse_mode_r == MODE_GLOW) || glow_enable_r);
  assign tilde_on = (parse_mode_r == MODE_TILDE) && tilde_enable_r;
  assign fin      = in_end_only || in_is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_mode_r   <= MODE_COPY;
      glow_enable_r  <= 1'b0;
      tilde_enable_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PARSE_MODE:   parse_mode_r   <= cfg_data[1:0];
        REG_GLOW_ENABLE:  glow_enable_r  <= cfg_data[0];
        REG_TILDE_ENABLE: tilde_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hd0_r <= hd0_nxt;
      hd1_r <= hd1_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    hd0_nxt   = hd0_r;
    hd1_nxt   = hd1_r;
    do_fresh  = 1'b0;
    n         = 2'd0;
    rel       = '0;

    if (!in_end_only) begin
      unique case (state_r)
        ST_IDLE: begin
          do_fresh = 1'b1;
        end
        ST_TIL: begin
          if (in_byte == CH_AMP) begin
            state_nxt = ST_TA;
          end else begin
            rel[0]   = CH_TILDE;
            n        = 2'd1;
            do_fresh = 1'b1;
          end
        end
        ST_TA: begin
          if (in_byte == CH_TILDE) begin
            state_nxt = ST_TAT;
          end else if (code_digit(in_byte)) begin
            hd0_nxt   = in_byte;
            state_nxt = ST_TAD1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        ST_TAT: begin
          if (in_byte == CH_AMP) begin
            rel[0]    = CH_TILDE;
            rel[1]    = CH_AMP;
            n         = 2'd2;
            state_nxt = ST_IDLE;
          end else begin
            do_fresh = 1'b1;
          end
        end
        ST_TAD1: begin
          if (code_digit(in_byte)) begin
            hd1_nxt   = in_byte;
            state_nxt = ST_TAD2;
          end else begin
            rel[0]   = hd0_r;
            n        = 2'd1;
            do_fresh = 1'b1;
          end
        end
        ST_TAD2: begin
          if (code_digit(in_byte)) begin
            state_nxt = ST_IDLE;
          end else begin
            rel[0]   = hd0_r;
            rel[1]   = hd1_r;
            n        = 2'd2;
            do_fresh = 1'b1;
          end
        end
        ST_CARET: begin
          if (in_byte == CH_CARET) begin
            rel[0]    = CH_CARET;
            n         = 2'd1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_CODE;
          end
        end
        ST_CODE: begin
          if (in_byte == CH_CARET) begin
            state_nxt = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end

    // a fresh byte may open markup or pass through
    if (do_fresh) begin
      priority if (glow_on && (in_byte == CH_CARET)) begin
        state_nxt = ST_CARET;
      end else if (tilde_on && (in_byte == CH_TILDE)) begin
        state_nxt = ST_TIL;
      end else begin
        rel[n]    = in_byte;
        n         = n + 2'd1;
        state_nxt = ST_IDLE;
      end
    end

    // settle pending bytes at the end of the string
    if (fin) begin
      unique case (state_nxt)
        ST_TIL: begin
          rel[n] = CH_TILDE;
          n      = n + 2'd1;
        end
        ST_TAD1: begin
          rel[0] = hd0_nxt;
          n      = 2'd1;
        end
        ST_TAD2: begin
          rel[0] = hd0_nxt;
          rel[1] = hd1_nxt;
          n      = 2'd2;
        end
        default: ;
      endcase
      state_nxt = ST_IDLE;
    end

    bnd.cnt   = n;
    bnd.fin   = fin;
    bnd.bytes = rel;
    bnd_valid = accept && ((n != 2'd0) || fin);
  end

endmodule

@@ sv/cms_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_queue
// Short queue of released-byte groups between the scanner and the emitter.
// ----------------------------------------------------------------------------
module cms_queue #(
  parameter int unsigned DEPTH = cms_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  cms_pkg::bundle_t wr_data,
  input  logic             rd_en,
  output cms_pkg::bundle_t rd_data,
  output logic             full,
  output logic             empty
);
  import cms_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t         mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + AW'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + AW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en || rd_en)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !rd_en)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count out of range");
`endif

endmodule

@@ sv/cms_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_back
// Walks head group bytes to the output register, one per cycle while popped.
// ----------------------------------------------------------------------------
module cms_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  cms_pkg::bundle_t head,
  output logic             head_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_string_end,
  output logic             out_run_last
);
  import cms_pkg::*;

  logic [1:0] k_r, k_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] byte_r;
  logic       has_r, send_r, last_r;
  logic       load, is_last;

  assign empty          = !ov_r;
  assign out_byte       = byte_r;
  assign out_has_byte   = has_r;
  assign out_string_end = send_r;
  assign out_run_last   = last_r;

  always_comb begin
    load     = head_valid && (!ov_r || pop);
    is_last  = (head.cnt == 2'd0) || (k_r == head.cnt - 2'd1);
    head_pop = load && is_last;
    k_nxt    = k_r;
    if (load) begin
      k_nxt = is_last ? 2'd0 : k_r + 2'd1;
    end
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= 2'd0;
      ov_r <= 1'b0;
    end else begin
      k_r  <= k_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= (head.cnt == 2'd0) ? 8'h00 : head.bytes[k_r];
      has_r  <= (head.cnt != 2'd0);
      send_r <= head.fin && is_last;
      last_r <= is_last;
    end
  end

`ifndef SYNTH
  a_index_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != 2'd0) |-> head_valid && (k_r < head.cnt))
    else $error("byte index outside the head group");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !pop) |=> ov_r && $stable(byte_r) && $stable(last_r))
    else $error("waiting result changed");
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> ov_r && last_r)
    else $error("group retired without its last result");
`endif

endmodule

@@ sv/color_markup_stripper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_markup_stripper
// Removes caret and tilde color markup from a byte stream, releasing plain text.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            in_byte, in_end_only, in_is_last
//  result    empty / pop            out_byte, out_has_byte, out_string_end,
//                                   out_run_last
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  The scanner decides each input byte combinationally and takes one byte per
//  cycle while the group queue has room. The emitter releases one result per
//  cycle while results are popped, one per released byte or one for a bare end.
//  Synchronous active-low reset returns the scanner to idle and empties the
//  queue and output register. cfg_ready is always high.
// ----------------------------------------------------------------------------
module color_markup_stripper #(
  parameter int unsigned QDEPTH = cms_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 in_byte,
  input  logic                       in_end_only,
  input  logic                       in_is_last,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 out_byte,
  output logic                       out_has_byte,
  output logic                       out_string_end,
  output logic                       out_run_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [cms_pkg::CFG_DW-1:0] cfg_data
);
  import cms_pkg::*;

  logic    q_full, q_empty, accept, bnd_valid, head_pop;
  bundle_t bnd, head;

  assign full      = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;

  cms_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_end_only (in_end_only),
    .in_is_last  (in_is_last),
    .bnd_valid   (bnd_valid),
    .bnd         (bnd)
  );

  cms_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bnd_valid),
    .wr_data (bnd),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  cms_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (!q_empty),
    .head           (head),
    .head_pop       (head_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_string_end (out_string_end),
    .out_run_last   (out_run_last)
  );

endmodule
